// ===== hdl/scspg_pkg.sv =====
// Shared types and constants for the S-curve step period generator.
// Used by scspg_div_cell and the top level; no dependencies.
package scspg_pkg;

   localparam int MAX_STEPS  = 256;
   localparam int NUM_W      = 42;   // dividend / quotient width of the divider cells
   localparam int DIV_W      = 32;   // divisor and remainder width
   localparam int T_CELLS    = 16;   // cells for the ramp position divide
   localparam int P_CELLS    = 42;   // cells for the period divide

   localparam logic [16:0] ONE_Q16      = 17'd65536;
   localparam logic [31:0] MIN_FREQ_MHZ = 32'd100;
   localparam logic [30:0] TOTAL_MIN    = 31'd3;
   localparam logic [30:0] TOTAL_MAX    = 31'h7fffffff;
   localparam logic [17:0] THREE_Q16    = 18'd196608;
   localparam logic [9:0]  MILLI_SCALE  = 10'd1000;

   localparam logic [2:0] CSR_CLOCK_HZ  = 3'd0;
   localparam logic [2:0] CSR_START_F   = 3'd1;
   localparam logic [2:0] CSR_TARGET_F  = 3'd2;
   localparam logic [2:0] CSR_DUTY      = 3'd3;
   localparam logic [2:0] CSR_STEPS     = 3'd4;

   typedef struct packed {
      logic              valid;
      logic [DIV_W-1:0]  rem;
      logic [DIV_W-1:0]  dvsr;
      logic [NUM_W-1:0]  num;
      logic              side;
   } div_stage_type;

endpackage

// ===== hdl/scspg_div_cell.sv =====
// One restoring-division cell: retires one quotient bit per transfer.
// Depends on scspg_pkg for the stage struct.
module scspg_div_cell import scspg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type up_in,
   input  logic          take_in,
   output div_stage_type cell_out,
   output logic          adv_out
);

   div_stage_type   cell_ff;
   div_stage_type   cell_in;
   logic [DIV_W:0]  part;
   logic            qbit;

   assign adv_out  = !cell_ff.valid || take_in;
   assign cell_out = cell_ff;

   always_comb begin
      part    = {up_in.rem, up_in.num[NUM_W-1]};
      qbit    = (part >= {1'b0, up_in.dvsr});
      cell_in = up_in;
      cell_in.rem = qbit ? DIV_W'(part - {1'b0, up_in.dvsr}) : part[DIV_W-1:0];
      cell_in.num = {up_in.num[NUM_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (adv_out) begin
         cell_ff <= cell_in;
      end
   end

endmodule

// ===== hdl/s_curve_step_period_generator_top.sv =====
// S-curve step period generator: ramp index or steady request in, pulse high/low counts out.
// Pipeline: 16 position-divide cells, 4 shaping stages, 42 period-divide cells,
// 3 output stages. Throughput one item per cycle while rsp_stall is low.
// Reset (synchronous) empties the pipeline and loads the register defaults.
// Depends on scspg_pkg and scspg_div_cell.
module s_curve_step_period_generator_top import scspg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_step_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [30:0] rsp_high_count,
   output logic [30:0] rsp_low_count,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] clock_hz_ff, start_f_ff, target_f_ff;
   logic [16:0] duty_ff;
   logic [8:0]  steps_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= 32'd125000000;
         start_f_ff  <= 32'd10000;
         target_f_ff <= 32'd1000000;
         duty_ff     <= 17'd32768;
         steps_ff    <= 9'd128;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_CLOCK_HZ: clock_hz_ff <= csr_data;
            CSR_START_F:  start_f_ff  <= csr_data;
            CSR_TARGET_F: target_f_ff <= csr_data;
            CSR_DUTY:     duty_ff     <= csr_data[16:0];
            CSR_STEPS:    steps_ff    <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // clamp ramp length and duty
   logic [8:0]  steps_c, last_c;
   logic [16:0] duty_c;
   always_comb begin
      steps_c = steps_ff;
      if (steps_ff < 9'd2) steps_c = 9'd2;
      if (steps_ff > 9'(MAX_STEPS)) steps_c = 9'(MAX_STEPS);
      last_c = steps_c - 9'd1;
      duty_c = (duty_ff > ONE_Q16) ? ONE_Q16 : duty_ff;
   end

   // advance flags, from the output back
   logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv_t0, adv_p0;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   // position divide: t = idx*65536 / (steps-1)
   div_stage_type t_head;
   div_stage_type t_q   [T_CELLS];
   logic          t_adv [T_CELLS];

   always_comb begin
      t_head       = '0;
      t_head.valid = req_valid;
      t_head.rem   = DIV_W'(req_step_index);
      t_head.dvsr  = DIV_W'(last_c[7:0]);
      t_head.side  = req_mode || ({1'b0, req_step_index} >= last_c);
   end

   for (genvar k = 0; k < T_CELLS; k++) begin : g_tcell
      if (k == 0) begin : g_first
         scspg_div_cell u_cell (.clock(clock), .reset(reset), .up_in(t_head),
            .take_in(t_adv[k+1]), .cell_out(t_q[k]), .adv_out(t_adv[k]));
      end else if (k == T_CELLS-1) begin : g_last
         scspg_div_cell u_cell (.clock(clock), .reset(reset), .up_in(t_q[k-1]),
            .take_in(adv1), .cell_out(t_q[k]), .adv_out(t_adv[k]));
      end else begin : g_mid
         scspg_div_cell u_cell (.clock(clock), .reset(reset), .up_in(t_q[k-1]),
            .take_in(t_adv[k+1]), .cell_out(t_q[k]), .adv_out(t_adv[k]));
      end
   end
   assign adv_t0    = t_adv[0];
   assign req_stall = !adv_t0;

   // stage 1: t squared
   logic [15:0] t1_ff;
   logic [31:0] tt1_ff;
   logic        full1_ff;
   logic [15:0] t_end;
   assign t_end = t_q[T_CELLS-1].num[15:0];
   assign adv1  = !v1_ff || adv2;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv1) begin
         v1_ff    <= t_q[T_CELLS-1].valid;
         t1_ff    <= t_end;
         tt1_ff   <= 32'(t_end) * 32'(t_end);
         full1_ff <= t_q[T_CELLS-1].side;
      end
   end

   // stage 2: smoothstep
   logic [16:0] s2_ff;
   logic [17:0] kk;
   logic [49:0] sprod;
   assign kk    = THREE_Q16 - {1'b0, t1_ff, 1'b0};
   assign sprod = 50'(tt1_ff) * 50'(kk);
   assign adv2  = !v2_ff || adv3;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv2) begin
         v2_ff <= v1_ff;
         s2_ff <= full1_ff ? ONE_Q16 : sprod[48:32];
      end
   end

   // stage 3: span times shape
   logic [48:0] fprod3_ff;
   logic        up3_ff;
   logic        up_c;
   logic [31:0] span_c;
   assign up_c   = (target_f_ff >= start_f_ff);
   assign span_c = up_c ? (target_f_ff - start_f_ff) : (start_f_ff - target_f_ff);
   assign adv3   = !v3_ff || adv4;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv3) begin
         v3_ff     <= v2_ff;
         fprod3_ff <= 49'(span_c) * 49'(s2_ff);
         up3_ff    <= up_c;
      end
   end

   // stage 4: frequency, clamp, scaled clock
   logic [31:0]      f4_ff, f_c;
   logic [NUM_W-1:0] n4_ff;
   always_comb begin
      f_c = up3_ff ? (start_f_ff + fprod3_ff[47:16]) : (start_f_ff - fprod3_ff[47:16]);
      if (f_c < MIN_FREQ_MHZ) f_c = MIN_FREQ_MHZ;
   end
   assign adv4 = !v4_ff || adv_p0;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv4) begin
         v4_ff <= v3_ff;
         f4_ff <= f_c;
         n4_ff <= NUM_W'(clock_hz_ff) * NUM_W'(MILLI_SCALE);
      end
   end

   // period divide: total = clock*1000 / f
   div_stage_type p_head;
   div_stage_type p_q   [P_CELLS];
   logic          p_adv [P_CELLS];
   always_comb begin
      p_head       = '0;
      p_head.valid = v4_ff;
      p_head.dvsr  = f4_ff;
      p_head.num   = n4_ff;
   end

   for (genvar k = 0; k < P_CELLS; k++) begin : g_pcell
      if (k == 0) begin : g_first
         scspg_div_cell u_cell (.clock(clock), .reset(reset), .up_in(p_head),
            .take_in(p_adv[k+1]), .cell_out(p_q[k]), .adv_out(p_adv[k]));
      end else if (k == P_CELLS-1) begin : g_last
         scspg_div_cell u_cell (.clock(clock), .reset(reset), .up_in(p_q[k-1]),
            .take_in(adv5), .cell_out(p_q[k]), .adv_out(p_adv[k]));
      end else begin : g_mid
         scspg_div_cell u_cell (.clock(clock), .reset(reset), .up_in(p_q[k-1]),
            .take_in(p_adv[k+1]), .cell_out(p_q[k]), .adv_out(p_adv[k]));
      end
   end
   assign adv_p0 = p_adv[0];

   // stage 5: saturate total
   logic [30:0]      tot5_ff;
   logic             sat5_ff;
   logic [NUM_W-1:0] q_end;
   assign q_end = p_q[P_CELLS-1].num;
   assign adv5  = !v5_ff || adv6;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv5) begin
         v5_ff <= p_q[P_CELLS-1].valid;
         if (q_end[NUM_W-1:31] != '0) begin
            tot5_ff <= TOTAL_MAX;
            sat5_ff <= 1'b1;
         end else if (q_end[30:0] < TOTAL_MIN) begin
            tot5_ff <= TOTAL_MIN;
            sat5_ff <= 1'b1;
         end else begin
            tot5_ff <= q_end[30:0];
            sat5_ff <= 1'b0;
         end
      end
   end

   // stage 6: duty split
   logic [30:0] tot6_ff;
   logic [31:0] hi6_ff;
   logic        sat6_ff;
   logic [47:0] hprod;
   assign hprod = 48'(tot5_ff) * 48'(duty_c);
   assign adv6  = !v6_ff || adv7;
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv6) begin
         v6_ff   <= v5_ff;
         tot6_ff <= tot5_ff;
         hi6_ff  <= hprod[47:16];
         sat6_ff <= sat5_ff;
      end
   end

   // stage 7: bound high time, hold result
   logic [30:0] hi_c;
   logic [30:0] hi7_ff, lo7_ff;
   logic        sat7_ff;
   always_comb begin
      hi_c = hi6_ff[30:0];
      if (hi6_ff == 32'd0) hi_c = 31'd1;
      if (hi6_ff >= {1'b0, tot6_ff}) hi_c = tot6_ff - 31'd1;
   end
   assign adv7 = !v7_ff || !rsp_stall;
   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv7) begin
         v7_ff   <= v6_ff;
         hi7_ff  <= hi_c;
         lo7_ff  <= tot6_ff - hi_c;
         sat7_ff <= sat6_ff;
      end
   end

   assign rsp_valid      = v7_ff;
   assign rsp_high_count = hi7_ff;
   assign rsp_low_count  = lo7_ff;
   assign rsp_saturated  = sat7_ff;

endmodule
